@@ hdl/rpsc_pkg.sv @@
// Package for the refcounted power state controller.
// Holds action, level and register codes, the configuration struct and result flags.
// No dependencies.
`timescale 1ns / 1ps

package rpsc_pkg;

  typedef enum logic [1:0] {
    ACT_BUSY    = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_TICK    = 2'd2,
    ACT_SUSPEND = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    LVL_RUN = 3'b001,
    LVL_CG  = 3'b010,
    LVL_PG  = 3'b100
  } level_e;

  typedef enum logic [1:0] {
    REG_CLOCK_GATE_DELAY     = 2'd0,
    REG_POWER_GATE_DELAY     = 2'd1,
    REG_POWER_GATING_ALLOWED = 2'd2,
    REG_RESET_AFTER_POWER_UP = 2'd3
  } reg_idx_e;

  localparam logic [1:0] CODE_RUN = 2'd0;
  localparam logic [1:0] CODE_CG  = 2'd1;
  localparam logic [1:0] CODE_PG  = 2'd2;

  localparam logic [15:0] CLOCK_GATE_DELAY_RST     = 16'd25;
  localparam logic [15:0] POWER_GATE_DELAY_RST     = 16'd100;
  localparam logic        POWER_GATING_ALLOWED_RST = 1'b1;
  localparam logic        RESET_AFTER_POWER_UP_RST = 1'b0;

  typedef struct packed {
    logic [15:0] clock_gate_delay;
    logic [15:0] power_gate_delay;
    logic        power_gating_allowed;
    logic        reset_after_power_up;
  } cfg_t;

  typedef struct packed {
    logic count_error;
    logic suspend_refused;
    logic went_idle;
    logic context_restore;
    logic module_reset;
    logic partition_on;
    logic clocks_on;
  } flags_t;

endpackage

@@ hdl/rpsc_step.sv @@
// Next-state and result logic for one word of the power state controller.
// Pure combinational; depends on rpsc_pkg.
`timescale 1ns / 1ps

module rpsc_step
  import rpsc_pkg::*;
#(
  parameter int MAX_USERS  = 255,
  parameter int DELAY_BITS = 16,
  localparam int UserW = $clog2(MAX_USERS + 1)
) (
  input  cfg_t                  cfg_i,
  input  action_e               action_i,
  input  logic [7:0]            release_count_i,
  input  level_e                level_i,
  input  logic [UserW-1:0]      ref_i,
  input  logic                  armed_i,
  input  logic [DELAY_BITS-1:0] left_i,
  output level_e                level_o,
  output logic [UserW-1:0]      ref_o,
  output logic                  armed_o,
  output logic [DELAY_BITS-1:0] left_o,
  output logic [1:0]            power_level_o,
  output logic [7:0]            users_o,
  output flags_t                flags_o
);

  localparam int CmpW = (UserW > 8) ? UserW : 8;

  function automatic logic [DELAY_BITS-1:0] sat_delay(input logic [15:0] d);
    logic [32:0] cap;
    logic [32:0] ext;
    cap = (33'd1 << DELAY_BITS) - 33'd1;
    ext = {17'd0, d};
    if (ext > cap) begin
      return cap[DELAY_BITS-1:0];
    end
    return ext[DELAY_BITS-1:0];
  endfunction

  logic [CmpW-1:0] ref_ext;
  logic [CmpW-1:0] drop_ext;
  logic [CmpW-1:0] diff;
  logic [CmpW-1:0] ref_wide;
  logic            lvl_pg;

  assign ref_ext  = CmpW'(ref_i);
  assign drop_ext = CmpW'(release_count_i);
  assign diff     = ref_ext - drop_ext;
  assign lvl_pg   = (level_i != LVL_RUN) && (level_i != LVL_CG);

  always_comb begin
    level_o = level_i;
    ref_o   = ref_i;
    armed_o = armed_i;
    left_o  = left_i;
    flags_o = '0;
    case (action_i)
      ACT_BUSY: begin
        armed_o = 1'b0;
        if (ref_i >= UserW'(MAX_USERS)) begin
          ref_o               = UserW'(MAX_USERS);
          flags_o.count_error = 1'b1;
        end else begin
          ref_o = ref_i + UserW'(1);
        end
        if (lvl_pg) begin
          flags_o.context_restore = 1'b1;
          flags_o.module_reset    = cfg_i.power_gating_allowed & cfg_i.reset_after_power_up;
        end
        level_o = LVL_RUN;
      end
      ACT_RELEASE: begin
        if (drop_ext > ref_ext) begin
          ref_o               = '0;
          flags_o.count_error = 1'b1;
        end else begin
          ref_o = diff[UserW-1:0];
        end
        if (ref_o == '0) begin
          flags_o.went_idle = 1'b1;
          if (level_i == LVL_RUN && !armed_i) begin
            armed_o = 1'b1;
            left_o  = sat_delay(cfg_i.clock_gate_delay);
          end
        end
      end
      ACT_TICK: begin
        if (armed_i) begin
          if (left_i <= DELAY_BITS'(1)) begin
            left_o  = '0;
            armed_o = 1'b0;
            if (ref_i == '0) begin
              if (level_i == LVL_RUN) begin
                level_o = LVL_CG;
                if (cfg_i.power_gating_allowed) begin
                  armed_o = 1'b1;
                  left_o  = sat_delay(cfg_i.power_gate_delay);
                end
              end else if (level_i == LVL_CG) begin
                level_o = LVL_PG;
              end
            end
          end else begin
            left_o = left_i - DELAY_BITS'(1);
          end
        end
      end
      default: begin
        if (ref_i != '0) begin
          flags_o.suspend_refused = 1'b1;
        end else begin
          armed_o = 1'b0;
          left_o  = '0;
          level_o = LVL_PG;
        end
      end
    endcase

    case (level_o)
      LVL_RUN: power_level_o = CODE_RUN;
      LVL_CG:  power_level_o = CODE_CG;
      default: power_level_o = CODE_PG;
    endcase
    flags_o.clocks_on    = (level_o == LVL_RUN);
    flags_o.partition_on = !((level_o != LVL_RUN) && (level_o != LVL_CG)
                             && cfg_i.power_gating_allowed);
  end

  assign ref_wide = CmpW'(ref_o);
  assign users_o  = ref_wide[7:0];

endmodule

@@ hdl/refcounted_power_state_controller.sv @@
// Refcounted power state controller: one input word per clock updates the user count,
// the power level and the gating timer; the result word is captured in an output
// register and a new word is taken every cycle unless that register is stalled.
// The rate is set by the update loop of level, count and timer registers.
// Configuration goes through the APB port at addresses 0, 4, 8 and 12.
// Depends on rpsc_pkg and rpsc_step.
`timescale 1ns / 1ps

module refcounted_power_state_controller
  import rpsc_pkg::*;
#(
  parameter int MAX_USERS  = 255,
  parameter int DELAY_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] release_count
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [1:0] power_level, [9:2] users, [10] clocks_on, [11] partition_on,
  // [12] module_reset, [13] context_restore, [14] went_idle,
  // [15] suspend_refused, [16] count_error, [23:17] zero
  output logic [23:0] m_axis_tdata_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  localparam int UserW = $clog2(MAX_USERS + 1);

  cfg_t                  cfg_q;
  level_e                level_q, level_d;
  logic [UserW-1:0]      ref_q, ref_d;
  logic                  armed_q, armed_d;
  logic [DELAY_BITS-1:0] left_q, left_d;
  logic                  out_valid_q;
  logic [23:0]           out_data_q, out_data_d;
  logic [1:0]            power_level;
  logic [7:0]            users;
  flags_t                flags;
  logic                  in_acc;
  logic                  cfg_wr;
  reg_idx_e              reg_idx;

  assign pready_o        = 1'b1;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_wr          = psel_i && penable_i && pwrite_i;
  assign reg_idx         = reg_idx_e'(paddr_i[3:2]);

  rpsc_step #(
    .MAX_USERS (MAX_USERS),
    .DELAY_BITS(DELAY_BITS)
  ) u_step (
    .cfg_i          (cfg_q),
    .action_i       (action_e'(s_axis_tuser_i)),
    .release_count_i(s_axis_tdata_i),
    .level_i        (level_q),
    .ref_i          (ref_q),
    .armed_i        (armed_q),
    .left_i         (left_q),
    .level_o        (level_d),
    .ref_o          (ref_d),
    .armed_o        (armed_d),
    .left_o         (left_d),
    .power_level_o  (power_level),
    .users_o        (users),
    .flags_o        (flags)
  );

  assign out_data_d = {7'd0, flags.count_error, flags.suspend_refused, flags.went_idle,
                       flags.context_restore, flags.module_reset, flags.partition_on,
                       flags.clocks_on, users, power_level};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clock_gate_delay     <= CLOCK_GATE_DELAY_RST;
      cfg_q.power_gate_delay     <= POWER_GATE_DELAY_RST;
      cfg_q.power_gating_allowed <= POWER_GATING_ALLOWED_RST;
      cfg_q.reset_after_power_up <= RESET_AFTER_POWER_UP_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_CLOCK_GATE_DELAY:     cfg_q.clock_gate_delay     <= pwdata_i[15:0];
        REG_POWER_GATE_DELAY:     cfg_q.power_gate_delay     <= pwdata_i[15:0];
        REG_POWER_GATING_ALLOWED: cfg_q.power_gating_allowed <= pwdata_i[0];
        REG_RESET_AFTER_POWER_UP: cfg_q.reset_after_power_up <= pwdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CLOCK_GATE_DELAY:     prdata_o = {16'd0, cfg_q.clock_gate_delay};
      REG_POWER_GATE_DELAY:     prdata_o = {16'd0, cfg_q.power_gate_delay};
      REG_POWER_GATING_ALLOWED: prdata_o = {31'd0, cfg_q.power_gating_allowed};
      REG_RESET_AFTER_POWER_UP: prdata_o = {31'd0, cfg_q.reset_after_power_up};
      default:                  prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= LVL_PG;
      ref_q       <= '0;
      armed_q     <= 1'b0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        level_q <= level_d;
        ref_q   <= ref_d;
        armed_q <= armed_d;
        left_q  <= left_d;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_ref_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ref_q <= UserW'(MAX_USERS))
    else $error("user count above limit");

  a_armed_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |-> (ref_q == '0) && (level_q != LVL_PG))
    else $error("timer armed with users held or while power gated");

  a_busy_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (s_axis_tuser_i == ACT_BUSY) |=> level_q == LVL_RUN)
    else $error("busy word did not bring module to running");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> m_axis_tvalid_o)
    else $error("accepted word produced no result");

endmodule
